// File: hw/rtl/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ARPR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ARPR_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ARPR_ASSERT(lbl, clk, rst_n, prop, msg)

`define ARPR_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: hw/rtl/arpr_pkg.sv
package arpr_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_end;
    } t_rx_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_end;
    } t_tx_item;

    // one pending reply: what the back end needs from the request
    typedef struct packed {
        logic [47:0] peer_mac;
        logic [31:0] peer_ipv4;
    } t_job;

    localparam logic [5:0] POS_SRC_MAC  = 6'd6;
    localparam logic [5:0] POS_TYPE_HI  = 6'd12;
    localparam logic [5:0] POS_TYPE_LO  = 6'd13;
    localparam logic [5:0] POS_OP_HI    = 6'd20;
    localparam logic [5:0] POS_OP_LO    = 6'd21;
    localparam logic [5:0] POS_SPA      = 6'd28;
    localparam logic [5:0] POS_SPA_END  = 6'd32;
    localparam logic [5:0] POS_TPA      = 6'd38;
    localparam logic [5:0] POS_TPA_LAST = 6'd41;
    localparam logic [5:0] HEAD_LEN     = 6'd42;
    localparam logic [5:0] REPLY_LAST   = 6'd59;

    localparam logic [7:0] ETYPE_HI = 8'h08;
    localparam logic [7:0] ETYPE_LO = 8'h06;
    localparam logic [7:0] OP_HI    = 8'h00;
    localparam logic [7:0] OP_REQ   = 8'h01;
    localparam logic [7:0] OP_REPLY = 8'h02;
    localparam logic [7:0] HTYPE_LO = 8'h01;
    localparam logic [7:0] PTYPE_HI = 8'h08;
    localparam logic [7:0] PTYPE_LO = 8'h00;
    localparam logic [7:0] HLEN     = 8'h06;
    localparam logic [7:0] PLEN     = 8'h04;

    localparam int JOB_DEPTH = 2;

    localparam logic PADDR_OWN_MAC  = 1'b0;
    localparam logic PADDR_OWN_IPV4 = 1'b1;

    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            3'd5:    b = mac[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = ip[31:24];
            2'd1:    b = ip[23:16];
            2'd2:    b = ip[15:8];
            default: b = ip[7:0];
        endcase
        return b;
    endfunction

    function automatic logic [7:0] reply_byte(input logic [5:0] idx, input t_job job,
                                              input logic [47:0] own_mac,
                                              input logic [31:0] own_ipv4);
        logic [7:0] b;
        logic [5:0] off;
        b   = 8'h00;
        off = 6'd0;
        if (idx < 6'd6) begin
            b = mac_byte(job.peer_mac, idx[2:0]);
        end else if (idx < 6'd12) begin
            off = idx - 6'd6;
            b   = mac_byte(own_mac, off[2:0]);
        end else if (idx < 6'd22) begin
            case (idx)
                6'd12:   b = ETYPE_HI;
                6'd13:   b = ETYPE_LO;
                6'd14:   b = OP_HI;
                6'd15:   b = HTYPE_LO;
                6'd16:   b = PTYPE_HI;
                6'd17:   b = PTYPE_LO;
                6'd18:   b = HLEN;
                6'd19:   b = PLEN;
                6'd20:   b = OP_HI;
                6'd21:   b = OP_REPLY;
                default: b = 8'h00;
            endcase
        end else if (idx < 6'd28) begin
            off = idx - 6'd22;
            b   = mac_byte(own_mac, off[2:0]);
        end else if (idx < 6'd32) begin
            off = idx - 6'd28;
            b   = ip_byte(own_ipv4, off[1:0]);
        end else if (idx < 6'd38) begin
            off = idx - 6'd32;
            b   = mac_byte(job.peer_mac, off[2:0]);
        end else if (idx < 6'd42) begin
            off = idx - 6'd38;
            b   = ip_byte(job.peer_ipv4, off[1:0]);
        end
        return b;
    endfunction

endpackage

// File: hw/rtl/arpr_rx_parser.sv
module arpr_rx_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  arpr_pkg::t_rx_item i_rx,
    input  logic [31:0]       i_own_ipv4,
    output logic              o_job_push,
    output arpr_pkg::t_job    o_job
);
    import arpr_pkg::*;

    logic [5:0]  r_pos, n_pos;
    logic [47:0] r_peer_mac, n_peer_mac;
    logic [31:0] r_peer_ipv4, n_peer_ipv4;
    logic        r_match, n_match;
    logic [5:0]  tpa_off;
    logic [7:0]  b;

    assign b       = i_rx.rx_byte;
    assign tpa_off = r_pos - POS_TPA;

    always_comb begin
        n_pos       = r_pos;
        n_peer_mac  = r_peer_mac;
        n_peer_ipv4 = r_peer_ipv4;
        n_match     = r_match;
        o_job_push  = 1'b0;
        if (i_accept) begin
            // peer fields are shifted in; they are complete before the last target byte
            if (r_pos >= POS_SRC_MAC && r_pos < POS_TYPE_HI) begin
                n_peer_mac = {r_peer_mac[39:0], b};
            end else if (r_pos == POS_TYPE_HI) begin
                if (b != ETYPE_HI) n_match = 1'b0;
            end else if (r_pos == POS_TYPE_LO) begin
                if (b != ETYPE_LO) n_match = 1'b0;
            end else if (r_pos == POS_OP_HI) begin
                if (b != OP_HI) n_match = 1'b0;
            end else if (r_pos == POS_OP_LO) begin
                if (b != OP_REQ) n_match = 1'b0;
            end else if (r_pos >= POS_SPA && r_pos < POS_SPA_END) begin
                n_peer_ipv4 = {r_peer_ipv4[23:0], b};
            end else if (r_pos >= POS_TPA && r_pos < HEAD_LEN) begin
                if (b != ip_byte(i_own_ipv4, tpa_off[1:0])) n_match = 1'b0;
                if (r_pos == POS_TPA_LAST && n_match) o_job_push = 1'b1;
            end
            if (r_pos < HEAD_LEN) n_pos = r_pos + 6'd1;
            if (i_rx.rx_end) begin
                n_pos   = 6'd0;
                n_match = 1'b1;
            end
        end
    end

    assign o_job.peer_mac  = r_peer_mac;
    assign o_job.peer_ipv4 = r_peer_ipv4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 6'd0;
            r_peer_mac  <= 48'h0;
            r_peer_ipv4 <= 32'h0;
            r_match     <= 1'b1;
        end else begin
            r_pos       <= n_pos;
            r_peer_mac  <= n_peer_mac;
            r_peer_ipv4 <= n_peer_ipv4;
            r_match     <= n_match;
        end
    end

endmodule

// File: hw/rtl/arpr_job_fifo.sv
`include "assert_macros.svh"

module arpr_job_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  arpr_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output arpr_pkg::t_job o_job
);
    import arpr_pkg::*;

    t_job       r_mem [JOB_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'(JOB_DEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = r_cnt + 2'd1;
        else if (!i_push && i_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    `ARPR_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= 2'(JOB_DEPTH), "job count overflow")
    `ARPR_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full, "job pushed while full")
    `ARPR_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && o_empty, "job popped while empty")
    `ARPR_ASSERT(a_ptr_cnt, i_clk, i_rst_n, (r_wp ^ r_rp) == r_cnt[0], "pointers disagree with count")

endmodule

// File: hw/rtl/arpr_tx_seq.sv
module arpr_tx_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  arpr_pkg::t_job     i_job,
    input  logic [47:0]        i_own_mac,
    input  logic [31:0]        i_own_ipv4,
    input  logic               i_pop,
    output logic               o_job_pop,
    output logic               o_empty,
    output arpr_pkg::t_tx_item o_tx
);
    import arpr_pkg::*;

    logic [5:0] r_idx;
    logic       r_out_valid;
    t_tx_item   r_out;
    logic       advance;
    logic       emit;
    logic       last;

    // output register frees up when empty or when its byte is taken
    assign advance   = !r_out_valid || i_pop;
    assign emit      = advance && i_job_valid;
    assign last      = (r_idx == REPLY_LAST);
    assign o_job_pop = emit && last;
    assign o_empty   = !r_out_valid;
    assign o_tx      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 6'd0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= i_job_valid;
            if (i_job_valid) r_idx <= last ? 6'd0 : r_idx + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.tx_byte <= reply_byte(r_idx, i_job, i_own_mac, i_own_ipv4);
            r_out.tx_end  <= last;
        end
    end

endmodule

// File: hw/rtl/arp_request_responder_core.sv
// a reply's first byte passes through the job queue and then the output register to the outputs
// after the edge that takes the last target-ip byte, when the sequencer is idle
// throughput: one frame byte per cycle in while full is low, one reply byte per cycle out while pop is high
// a reply occupies the output sequencer for 60 bytes; a 2-entry job queue buffers
// matched requests, and full is high while that queue holds 2 pending replies
// reset: synchronous active-low; clears frame tracking, queue and output, own_mac/own_ipv4 to 0
module arp_request_responder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  arpr_pkg::t_rx_item i_rx,
    output logic               empty,
    input  logic               pop,
    output arpr_pkg::t_tx_item o_tx,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import arpr_pkg::*;

    logic [47:0] r_own_mac;
    logic [31:0] r_own_ipv4;
    logic        accept;
    logic        cfg_wr;
    logic        job_push;
    logic        job_pop;
    logic        job_empty;
    t_job        job_in;
    t_job        job_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign accept = push && !full;

    always_comb begin
        case (paddr[3])
            PADDR_OWN_MAC:  prdata = {16'h0000, r_own_mac};
            PADDR_OWN_IPV4: prdata = {32'h0000_0000, r_own_ipv4};
            default:        prdata = 64'h0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac  <= 48'h0;
            r_own_ipv4 <= 32'h0;
        end else if (cfg_wr) begin
            if (paddr[3] == PADDR_OWN_MAC) r_own_mac <= pwdata[47:0];
            else r_own_ipv4 <= pwdata[31:0];
        end
    end

    arpr_rx_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_rx       (i_rx),
        .i_own_ipv4 (r_own_ipv4),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    arpr_job_fifo u_jobs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_full  (full),
        .o_empty (job_empty),
        .o_job   (job_head)
    );

    arpr_tx_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!job_empty),
        .i_job       (job_head),
        .i_own_mac   (r_own_mac),
        .i_own_ipv4  (r_own_ipv4),
        .i_pop       (pop),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .o_tx        (o_tx)
    );

endmodule

// File: dv/tb_arp_request_responder_core.sv
`timescale 1ns / 1ps

module tb_arp_request_responder_core;
    import arpr_pkg::*;

    localparam logic [3:0] ADDR_OWN_MAC  = {PADDR_OWN_MAC, 3'b000};
    localparam logic [3:0] ADDR_OWN_IPV4 = {PADDR_OWN_IPV4, 3'b000};
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_rx_item    i_rx = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_tx_item    o_tx;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    arp_request_responder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_rx    (i_rx),
        .empty   (empty),
        .pop     (pop),
        .o_tx    (o_tx),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // station model
    logic [47:0] own_mac_m = '0;
    logic [31:0] own_ipv4_m = '0;
    logic [47:0] peer_mac_m = '0;
    logic [31:0] peer_ipv4_m = '0;
    logic        match_m = 1'b1;
    int          rx_pos = 0;

    t_tx_item    reply_bytes_due[$];
    logic [7:0]  frame_buf[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          bytes_sent = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;

    logic        take_tx;
    logic        took_rx;
    logic        took_cfg;
    t_tx_item    seen_tx;

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    // queue the 60 reply bytes built from the current peer and station values
    task automatic queue_arp_reply();
        logic [8*42-1:0] head;
        t_tx_item        t;
        head = {peer_mac_m, own_mac_m, ETYPE_HI, ETYPE_LO, OP_HI, HTYPE_LO,
                PTYPE_HI, PTYPE_LO, HLEN, PLEN, OP_HI, OP_REPLY,
                own_mac_m, own_ipv4_m, peer_mac_m, peer_ipv4_m};
        for (int k = 0; k <= REPLY_LAST; k++) begin
            t.tx_byte = (k < HEAD_LEN) ? head[8*(41-k) +: 8] : 8'h00;
            t.tx_end  = (k == REPLY_LAST);
            reply_bytes_due.push_back(t);
        end
    endtask

    task automatic predict_arp(input logic [7:0] b, input logic e);
        int p;
        p = rx_pos;
        if (p >= POS_SRC_MAC && p < POS_TYPE_HI) begin
            peer_mac_m[8*(11-p) +: 8] = b;
        end else if (p == POS_TYPE_HI) begin
            if (b != ETYPE_HI) match_m = 1'b0;
        end else if (p == POS_TYPE_LO) begin
            if (b != ETYPE_LO) match_m = 1'b0;
        end else if (p == POS_OP_HI) begin
            if (b != OP_HI) match_m = 1'b0;
        end else if (p == POS_OP_LO) begin
            if (b != OP_REQ) match_m = 1'b0;
        end else if (p >= POS_SPA && p < POS_SPA_END) begin
            peer_ipv4_m[8*(31-p) +: 8] = b;
        end else if (p >= POS_TPA && p <= POS_TPA_LAST) begin
            if (b != own_ipv4_m[8*(41-p) +: 8]) match_m = 1'b0;
            if (p == POS_TPA_LAST && match_m) queue_arp_reply();
        end
        if (p < HEAD_LEN) rx_pos = p + 1;
        if (e) begin
            rx_pos  = 0;
            match_m = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at %0t: %s got %02h want %02h", $realtime, what, got, want);
        error_count++;
    endtask

    // receiver side: sample mid-cycle, act on the following rising edge
    always begin
        @(negedge i_clk);
        take_tx  = i_rst_n && pop && !empty;
        took_rx  = push && !full;
        took_cfg = psel && penable && pwrite && pready;
        seen_tx  = o_tx;
        @(posedge i_clk);
        if (take_tx) begin
            if (reply_bytes_due.size() == 0) begin
                report_mismatch("reply byte with no request pending", seen_tx.tx_byte, 8'h00);
            end else begin
                if (seen_tx.tx_byte !== reply_bytes_due[0].tx_byte)
                    report_mismatch("tx_byte", seen_tx.tx_byte, reply_bytes_due[0].tx_byte);
                if (seen_tx.tx_end !== reply_bytes_due[0].tx_end)
                    report_mismatch("tx_end", {7'd0, seen_tx.tx_end},
                                    {7'd0, reply_bytes_due[0].tx_end});
                void'(reply_bytes_due.pop_front());
            end
        end
        if (i_rst_n) begin
            if (take_tx || took_rx || took_cfg) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // push stays high after acceptance so the next byte can follow back to back
    task automatic send_byte(input logic [7:0] b, input logic e);
        logic acc;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_rx.rx_byte <= b;
        i_rx.rx_end  <= e;
        do begin
            @(negedge i_clk);
            acc = !full;
            @(posedge i_clk);
        end while (!acc);
        predict_arp(b, e);
        bytes_sent++;
    endtask

    task automatic send_frame(input bit with_end);
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], with_end && (i == frame_buf.size() - 1));
    endtask

    function automatic void build_request(input logic [47:0] src, input logic [31:0] spa,
                                          input logic [31:0] tpa);
        logic [8*42-1:0] v;
        logic [47:0]     dst;
        dst = $urandom_range(1) ? 48'hffff_ffff_ffff : rand48();
        v = {dst, src, ETYPE_HI, ETYPE_LO, OP_HI, HTYPE_LO, PTYPE_HI, PTYPE_LO,
             HLEN, PLEN, OP_HI, OP_REQ, src, spa, rand48(), tpa};
        frame_buf.delete();
        for (int i = 0; i < HEAD_LEN; i++) frame_buf.push_back(v[8*(41-i) +: 8]);
    endfunction

    function automatic int check_pos(input int sel);
        case (sel)
            0:       return POS_TYPE_HI;
            1:       return POS_TYPE_LO;
            2:       return POS_OP_HI;
            3:       return POS_OP_LO;
            default: return POS_TPA + sel - 4;
        endcase
    endfunction

    task automatic write_reg(input logic [3:0] addr, input logic [63:0] value);
        logic acc;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            acc = pready;
            @(posedge i_clk);
        end while (!acc);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_OWN_MAC) own_mac_m = value[47:0];
        else own_ipv4_m = value[31:0];
        @(posedge i_clk);
    endtask

    // junk above the register widths must be dropped
    task automatic set_station(input logic [47:0] mac, input logic [31:0] ip);
        logic [63:0] v;
        v = {$urandom, $urandom};
        v[47:0] = mac;
        write_reg(ADDR_OWN_MAC, v);
        v = {$urandom, $urandom};
        v[31:0] = ip;
        write_reg(ADDR_OWN_IPV4, v);
    endtask

    task automatic wait_replies_done();
        push <= 1'b0;
        while (reply_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reply_after_reset();
        // station registers still at reset value, request ends on final target byte
        build_request(48'h0, 32'h0, 32'h0);
        send_frame(1'b1);
        wait_replies_done();
    endtask

    task automatic test_register_extremes();
        set_station(48'hffff_ffff_ffff, 32'hffff_ffff);
        build_request(48'hffff_ffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        repeat (18) frame_buf.push_back(8'hff);
        send_frame(1'b1);
        wait_replies_done();
    endtask

    task automatic test_check_failures();
        int pos;
        set_station(rand48(), $urandom);
        // opcode low byte, then last target byte
        for (int sel = 3; sel < 8; sel += 4) begin
            pos = check_pos(sel);
            build_request(rand48(), $urandom, own_ipv4_m);
            frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(1, 255));
            send_frame(1'b1);
        end
        wait_replies_done();
    endtask

    task automatic test_short_and_unterminated();
        build_request(rand48(), $urandom, own_ipv4_m);
        frame_buf.pop_back();
        send_frame(1'b1);
        // no end marker: the request still replies and the lone end byte lands past the header
        build_request(rand48(), $urandom, own_ipv4_m);
        send_frame(1'b0);
        send_byte(8'h00, 1'b1);
        wait_replies_done();
    endtask

    task automatic test_back_to_back();
        // replies drain slower than requests arrive, so the job queue fills
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 4; i++) begin
            build_request(rand48(), $urandom, own_ipv4_m);
            send_frame(1'b1);
        end
        wait_replies_done();
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int start;
        int kind;
        int pos;
        bit with_end;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            kind     = $urandom_range(99);
            with_end = 1'b1;
            build_request(rand48(), $urandom,
                          ($urandom_range(9) == 0) ? $urandom : own_ipv4_m);
            if (kind < 55) begin
                repeat ($urandom_range(0, 18)) frame_buf.push_back(8'($urandom));
            end else if (kind < 70) begin
                pos = check_pos($urandom_range(7));
                frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(1, 255));
            end else if (kind < 80) begin
                while (frame_buf.size() > 1 && $urandom_range(7) != 0) frame_buf.pop_back();
            end else if (kind < 92) begin
                frame_buf.delete();
                repeat ($urandom_range(1, 64)) frame_buf.push_back(8'($urandom));
            end else begin
                with_end = 1'b0;
            end
            send_frame(with_end);
        end
        send_byte(8'($urandom), 1'b1);
        wait_replies_done();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 31;
        recv_idle_pct = 74;
        test_reply_after_reset();
        test_register_extremes();
        test_check_failures();

        send_idle_pct = 74;
        recv_idle_pct = 31;
        test_short_and_unterminated();
        set_station(rand48(), $urandom);
        test_random_traffic(60);

        test_back_to_back();

        wait_replies_done();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
